### rtl/pae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pae_pkg
// Shared codes, sizes and types for the positional array editor.
// ----------------------------------------------------------------------------
package pae_pkg;

  // default number of elements the store holds
  localparam int DEPTH_DEF = 128;

  // element and field widths
  localparam int ELEM_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
  localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // control states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SHIFT  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

### rtl/positional_array_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_editor
// Ordered array of signed 32-bit elements with append, delete, insert,
// overwrite and read by 1-based position; one result per request.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_ready  | op, position, value
//  out     | out_valid / out_ready| status, count, read_data
//
//  append, overwrite, read and any rejected request go from idle straight to
//  finish; the result is registered once the output register is free, and the
//  next request is taken back in idle. delete moves the entries after position
//  and insert the entry at position and those after it through the element RAM
//  at one per cycle in the shift state (none for a delete of the last element).
//  the RAM read port plus write port sets the one-element-per-cycle move.
//  synchronous reset clears the count, control and output valid; no RAM clear.
//  one result may wait in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module positional_array_editor
  import pae_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            op,
  input  logic [POS_W-1:0]           position,
  input  logic signed [ELEM_W-1:0]   value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic [COUNT_W-1:0]         count,
  output logic signed [ELEM_W-1:0]   read_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // control state
  state_t               state, state_next;
  logic [CW-1:0]        elem_count, elem_count_next;
  logic                 issuing, issuing_next;
  logic                 rd_pend, rd_pend_next;
  logic                 out_valid_next;

  // request payload held while it is worked on
  logic [OP_W-1:0]      op_q, op_q_next;
  logic [STATUS_W-1:0]  status_q, status_q_next;
  logic [ELEM_W-1:0]    val_q, val_q_next;
  logic [AW-1:0]        idx_q, idx_q_next;
  logic [AW-1:0]        ptr, ptr_next;
  logic [AW-1:0]        end_q, end_q_next;
  logic [AW-1:0]        dst_q, dst_q_next;

  // RAM ports
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [ELEM_W-1:0]    ram_wdata, ram_rdata;

  // request decode helpers
  logic                 accept, pos_ok, full, out_free;
  logic [AW-1:0]        pos_idx;
  logic [POS_W-1:0]     pos_m1;

  pae_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // position check against the current count
  assign pos_m1  = position - POS_W'(1);
  assign pos_idx = AW'(pos_m1);
  assign pos_ok  = (position != '0) && (CMPW'(position) <= CMPW'(elem_count));
  assign full    = (elem_count == CW'(DEPTH));

  // next state, RAM access and request bookkeeping
  always_comb begin
    state_next      = state;
    elem_count_next = elem_count;
    issuing_next    = issuing;
    rd_pend_next    = 1'b0;
    op_q_next       = op_q;
    status_q_next   = status_q;
    val_q_next      = val_q;
    idx_q_next      = idx_q;
    ptr_next        = ptr;
    end_q_next      = end_q;
    dst_q_next      = dst_q;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = val_q;
    ram_re          = 1'b0;
    ram_raddr       = ptr;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_q_next     = op;
          val_q_next    = value;
          idx_q_next    = pos_idx;
          status_q_next = ST_OK;
          state_next    = S_FINISH;
          unique case (op)
            OP_APPEND: begin
              if (full) begin
                status_q_next = ST_FULL;
              end else begin
                ram_we          = 1'b1;
                ram_waddr       = AW'(elem_count);
                ram_wdata       = value;
                elem_count_next = elem_count + CW'(1);
              end
            end
            OP_DELETE: begin
              if (!pos_ok) begin
                status_q_next = ST_BADPOS;
              end else begin
                // move entries position .. count-1 down by one
                elem_count_next = elem_count - CW'(1);
                ptr_next        = AW'(position);
                end_q_next      = AW'(elem_count - CW'(1));
                issuing_next    = (CMPW'(position) < CMPW'(elem_count));
                state_next      = S_SHIFT;
              end
            end
            OP_INSERT: begin
              if (!pos_ok) begin
                status_q_next = ST_BADPOS;
              end else if (full) begin
                status_q_next = ST_FULL;
              end else begin
                // move entries count-1 down to idx up by one
                elem_count_next = elem_count + CW'(1);
                ptr_next        = AW'(elem_count - CW'(1));
                end_q_next      = pos_idx;
                issuing_next    = 1'b1;
                state_next      = S_SHIFT;
              end
            end
            OP_OVERWRITE: begin
              if (!pos_ok) begin
                status_q_next = ST_BADPOS;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_idx;
                ram_wdata = value;
              end
            end
            OP_READ: begin
              if (!pos_ok) begin
                status_q_next = ST_BADPOS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_idx;
              end
            end
            default: begin
              status_q_next = ST_BADPOS;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read side: one source entry per cycle
        if (issuing) begin
          ram_re       = 1'b1;
          ram_raddr    = ptr;
          rd_pend_next = 1'b1;
          if (op_q == OP_DELETE) begin
            dst_q_next = ptr - AW'(1);
            ptr_next   = ptr + AW'(1);
          end else begin
            dst_q_next = ptr + AW'(1);
            ptr_next   = ptr - AW'(1);
          end
          if (ptr == end_q) begin
            issuing_next = 1'b0;
          end
        end
        // write side: data read last cycle lands at its destination
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
        end else if (!issuing) begin
          // move drained: an insert places its value in the freed slot
          if (op_q == OP_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = idx_q;
            ram_wdata = val_q;
          end
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_next = out_valid;
    if ((state == S_FINISH) && out_free) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      issuing    <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      elem_count <= elem_count_next;
      issuing    <= issuing_next;
      rd_pend    <= rd_pend_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    status_q <= status_q_next;
    val_q    <= val_q_next;
    idx_q    <= idx_q_next;
    ptr      <= ptr_next;
    end_q    <= end_q_next;
    dst_q    <= dst_q_next;
  end

  // result capture
  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      status <= status_q;
      count  <= COUNT_W'(elem_count);
      if ((op_q == OP_READ) && (status_q == ST_OK)) begin
        read_data <= ram_rdata;
      end else begin
        read_data <= '0;
      end
    end
  end

endmodule

### rtl/pae_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pae_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/pae_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pae_checker
// Port-level checks for the positional array editor, bound to the top level.
// ----------------------------------------------------------------------------
module pae_checker
  import pae_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [OP_W-1:0]          op,
  input logic [POS_W-1:0]         position,
  input logic signed [ELEM_W-1:0] value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STATUS_W-1:0]      status,
  input logic [COUNT_W-1:0]       count,
  input logic signed [ELEM_W-1:0] read_data
);

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(count) && $stable(read_data))
    else $error("stalled result changed");

  // a rejected request returns zero data
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BADPOS || status == ST_FULL) |-> read_data == '0)
    else $error("nonzero read data on a rejected request");

  // full status only with a full store
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> count == COUNT_W'(DEPTH))
    else $error("full status with a store that is not full");

  // status code stays within its defined set
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_BADPOS || status == ST_FULL))
    else $error("undefined status code");

endmodule

bind positional_array_editor pae_checker #(.DEPTH(DEPTH)) u_pae_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .op        (op),
  .position  (position),
  .value     (value),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .count     (count),
  .read_data (read_data)
);

### tb/tb_positional_array_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_array_editor
// Self-checking bench for the positional array editor. A shadow array and
// count predict status, count and read data for every accepted request.
// A directed opening covers empty-store errors, position zero, the first
// and last positions, value extremes, unknown op codes and deletes at both
// ends. The random part alternates fill-to-full, drain and edit phases with
// noise and out-of-range positions mixed in. The sender idles in bursts,
// the receiver stalls on its own pattern and once holds off long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_positional_array_editor;
  import pae_pkg::*;

  localparam int ARRAY_DEPTH  = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 1500000;

  // ops that take a position
  localparam logic [OP_W-1:0] POSITIONAL_OPS [4] = '{OP_DELETE, OP_INSERT, OP_OVERWRITE, OP_READ};

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [ELEM_W-1:0] value;
  } edit_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic signed [ELEM_W-1:0] read_data;
  } edit_res_t;

  typedef enum int {FILL_GROW, FILL_SHRINK, FILL_EDIT} fill_mode_t;
  typedef enum int {RX_OPEN, RX_HALF, RX_LIGHT, RX_HEAVY} rx_style_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          op        = OP_APPEND;
  logic [POS_W-1:0]         position  = '0;
  logic signed [ELEM_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       count;
  logic signed [ELEM_W-1:0] read_data;

  edit_req_t pending_edits [$];
  edit_res_t expected_results [$];

  // shadow of the element store and count
  logic signed [ELEM_W-1:0] shadow_array [ARRAY_DEPTH];
  int shadow_count = 0;

  // element count as seen by the request generator
  int plan_count = 0;

  int error_n    = 0;
  int accepted_n = 0;
  int cycle_n    = 0;

  positional_array_editor #(.DEPTH(ARRAY_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .read_data (read_data)
  );

  always #6 clk = ~clk;

  // apply one request to the shadow array and return its result
  function automatic edit_res_t apply_edit(edit_req_t req);
    edit_res_t res;
    logic      pos_ok;
    int        idx;
    res.status    = ST_OK;
    res.read_data = '0;
    pos_ok = (req.position >= 1) && (int'(req.position) <= shadow_count);
    idx    = int'(req.position) - 1;
    case (req.op)
      OP_APPEND: begin
        if (shadow_count >= ARRAY_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_array[shadow_count] = req.value;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (!pos_ok) begin
          res.status = ST_BADPOS;
        end else begin
          for (int i = idx + 1; i < shadow_count; i++) shadow_array[i-1] = shadow_array[i];
          shadow_count--;
        end
      end
      OP_INSERT: begin
        // position check wins over full
        if (!pos_ok) begin
          res.status = ST_BADPOS;
        end else if (shadow_count >= ARRAY_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > idx; i--) shadow_array[i] = shadow_array[i-1];
          shadow_array[idx] = req.value;
          shadow_count++;
        end
      end
      OP_OVERWRITE: begin
        if (!pos_ok) res.status = ST_BADPOS;
        else shadow_array[idx] = req.value;
      end
      OP_READ: begin
        if (!pos_ok) res.status = ST_BADPOS;
        else res.read_data = shadow_array[idx];
      end
      default: begin
        res.status = ST_BADPOS;
      end
    endcase
    res.count = COUNT_W'(shadow_count);
    return res;
  endfunction

  // queue one request and track the count it leaves behind
  task automatic queue_edit(logic [OP_W-1:0] o, int pos, logic signed [ELEM_W-1:0] v);
    edit_req_t req;
    logic      pos_ok;
    req.op       = o;
    req.position = POS_W'(pos);
    req.value    = v;
    pending_edits.push_back(req);
    pos_ok = (req.position >= 1) && (int'(req.position) <= plan_count);
    case (o)
      OP_APPEND: if (plan_count < ARRAY_DEPTH) plan_count++;
      OP_DELETE: if (pos_ok) plan_count--;
      OP_INSERT: if (pos_ok && plan_count < ARRAY_DEPTH) plan_count++;
      default: ;
    endcase
  endtask

  // element values with the extremes favored
  function automatic logic signed [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int good_pos();
    if (plan_count == 0) return 0;
    return $urandom_range(1, plan_count);
  endfunction

  function automatic int bad_pos();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return (plan_count < 255) ? plan_count + 1 : 0;
      2: return 255;
      default: return (plan_count < 255) ? $urandom_range(plan_count + 1, 255) : 0;
    endcase
  endfunction

  // one random request shaped by the current fill phase
  task automatic queue_random(fill_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 7) begin
      queue_edit(OP_W'($urandom_range(0, 7)), $urandom_range(0, 255), pick_value());
    end else if (roll < 13) begin
      queue_edit(POSITIONAL_OPS[$urandom_range(0, 3)], bad_pos(), pick_value());
    end else begin
      case (mode)
        FILL_GROW: begin
          if (roll < 75 || plan_count == 0) queue_edit(OP_APPEND, $urandom_range(0, 255), pick_value());
          else queue_edit(OP_INSERT, good_pos(), pick_value());
        end
        FILL_SHRINK: begin
          if (roll < 85) queue_edit(OP_DELETE, good_pos(), pick_value());
          else queue_edit(OP_READ, good_pos(), pick_value());
        end
        default: begin
          if (roll < 45) queue_edit(OP_OVERWRITE, good_pos(), pick_value());
          else if (roll < 75) queue_edit(OP_READ, good_pos(), pick_value());
          else if (roll < 82) queue_edit(OP_APPEND, $urandom_range(0, 255), pick_value());
          else if (roll < 90) queue_edit(OP_INSERT, good_pos(), pick_value());
          else queue_edit(OP_DELETE, good_pos(), pick_value());
        end
      endcase
    end
  endtask

  // stimulus plan, reset and end of run
  initial begin
    fill_mode_t mode;
    int         random_n;
    int         target;

    // empty store, position zero and out of range
    queue_edit(OP_READ, 1, 0);
    queue_edit(OP_DELETE, 0, 0);
    queue_edit(OP_INSERT, 1, 5);
    queue_edit(OP_OVERWRITE, 1, 5);
    // loads with extreme values; append ignores position
    queue_edit(OP_APPEND, 255, 32'sh7fff_ffff);
    queue_edit(OP_APPEND, 0, 32'sh8000_0000);
    queue_edit(OP_APPEND, 128, 0);
    queue_edit(OP_READ, 3, 0);
    queue_edit(OP_READ, 4, 0);
    queue_edit(OP_READ, 0, 0);
    // insert at the front and at the last position
    queue_edit(OP_INSERT, 1, -1);
    queue_edit(OP_INSERT, 4, 12345);
    queue_edit(OP_OVERWRITE, 2, 32'sh5a5a_5a5a);
    for (int p = 1; p <= 5; p++) queue_edit(OP_READ, p, 0);
    // unknown op codes
    queue_edit(3'd5, 1, 7);
    queue_edit(3'd6, 2, 7);
    queue_edit(3'd7, 3, 7);
    // delete the last, the first, and out of range
    queue_edit(OP_DELETE, 5, 0);
    queue_edit(OP_DELETE, 1, 0);
    queue_edit(OP_DELETE, 255, 0);
    queue_edit(OP_READ, 1, 0);

    // random phases: first one fills the store
    random_n = 0;
    mode = FILL_GROW;
    while (random_n < RANDOM_ITEMS) begin
      case (mode)
        FILL_GROW: begin
          while (plan_count < ARRAY_DEPTH && random_n < RANDOM_ITEMS) begin
            queue_random(mode);
            random_n++;
          end
          // requests against a full store
          repeat ($urandom_range(2, 6)) begin
            case ($urandom_range(0, 2))
              0: queue_edit(OP_APPEND, $urandom_range(0, 255), pick_value());
              1: queue_edit(OP_INSERT, good_pos(), pick_value());
              default: queue_edit(OP_INSERT, bad_pos(), pick_value());
            endcase
            random_n++;
          end
        end
        FILL_SHRINK: begin
          target = $urandom_range(0, 16);
          while (plan_count > target && random_n < RANDOM_ITEMS) begin
            queue_random(mode);
            random_n++;
          end
        end
        default: begin
          repeat ($urandom_range(10, 80)) begin
            queue_random(mode);
            random_n++;
          end
        end
      endcase
      mode = fill_mode_t'($urandom_range(0, 2));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_edits.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (ARRAY_DEPTH + 20) @(posedge clk);
    if (error_n == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // request driver: bursts with random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    edit_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_edit('{op, position, value}));
        accepted_n++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_edits.size() != 0) begin
          req = pending_edits.pop_front();
          in_valid <= 1'b1;
          op       <= req.op;
          position <= req.position;
          value    <= req.value;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: stall pattern plus one long hold-off
  rx_style_t rx_style   = RX_OPEN;
  int        style_left = 0;
  int        hold_left  = 0;
  logic      hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted_n >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      case (rx_style)
        RX_OPEN:  out_ready <= 1'b1;
        RX_HALF:  out_ready <= $urandom_range(0, 1) == 1;
        RX_LIGHT: out_ready <= $urandom_range(0, 3) != 0;
        default:  out_ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // result monitor: compare against the oldest prediction
  always @(posedge clk) begin
    edit_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d count %0d read_data %0d",
               status, count, read_data);
        error_n++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          error_n++;
        end
        if (count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, count);
          error_n++;
        end
        if (read_data !== want.read_data) begin
          $error("read_data mismatch: expected %0d, actual %0d", want.read_data, read_data);
          error_n++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
